### rtl/fccm_pkg.sv
package fccm_pkg;

	// normalized fraction t, unsigned Q0.16
	localparam int T_BITS = 16;
	localparam logic [T_BITS-1:0] T_HALF = 16'h8000;
	localparam logic [T_BITS-1:0] T_MAX = 16'hFFFF;
	localparam int SEG_BITS = 14;

	localparam int SMOKE_BITS = 9;
	localparam logic [SMOKE_BITS-1:0] SMOKE_ONE = 9'd256;
	localparam int CHAN_BITS = 8;

	// quotient bits resolved per divider stage
	localparam int DIV_STEPS = 2;
	localparam int DIV_STAGES = T_BITS / DIV_STEPS;

	// front end two stages, divider, colour two stages
	localparam int LATENCY = 2 + DIV_STAGES + 2;

	typedef enum logic [1:0] {
		MODE_RAMP       = 2'd0,
		MODE_RAMP_SMOKE = 2'd1,
		MODE_GREY       = 2'd2,
		MODE_SMOKE_RAMP = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		CFG_MODE       = 2'd0,
		CFG_RANGE_LOW  = 2'd1,
		CFG_RANGE_HIGH = 2'd2
	} cfg_idx_t;

	// per item flags that ride alongside the divider
	typedef struct packed {
		logic empty;
		logic full;
		logic [SMOKE_BITS-1:0] sm;
	} side_t;

endpackage

### rtl/fccm_norm.sv
module fccm_norm
	import fccm_pkg::*;
#(
	parameter int SAMPLE_BITS = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  logic [SAMPLE_BITS-1:0] pressure,
	input  logic [SMOKE_BITS-1:0] smoke,
	input  logic [SAMPLE_BITS-1:0] range_low,
	input  logic [SAMPLE_BITS-1:0] range_high,
	output logic out_valid,
	output logic [SAMPLE_BITS-1:0] num,
	output logic [SAMPLE_BITS-1:0] den,
	output side_t side
);

	logic signed [SAMPLE_BITS:0] p_x, lo_x, hi_x, d_x;
	logic lt, ge;
	logic [SMOKE_BITS-1:0] sm_sat;

	logic v_s1, lt_s1, ge_s1, empty_s1;
	logic [SAMPLE_BITS-1:0] p_s1, d_s1;
	logic [SMOKE_BITS-1:0] sm_s1;

	logic v_s2;
	logic [SAMPLE_BITS-1:0] n_s2, d_s2, n_x;
	side_t side_s2;

	assign p_x = $signed({pressure[SAMPLE_BITS-1], pressure});
	assign lo_x = $signed({range_low[SAMPLE_BITS-1], range_low});
	assign hi_x = $signed({range_high[SAMPLE_BITS-1], range_high});
	assign d_x = hi_x - lo_x;
	assign lt = p_x < lo_x;
	assign ge = p_x >= hi_x;
	assign sm_sat = (smoke > SMOKE_ONE) ? SMOKE_ONE : smoke;

	// offset inside the range, fits unsigned once clamped
	assign n_x = p_s1 - range_low;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		p_s1 <= pressure;
		lt_s1 <= lt;
		ge_s1 <= ge;
		d_s1 <= d_x[SAMPLE_BITS-1:0];
		empty_s1 <= d_x[SAMPLE_BITS] || (d_x == '0);
		sm_s1 <= sm_sat;

		priority if (lt_s1) begin
			n_s2 <= '0;
		end else if (ge_s1) begin
			n_s2 <= d_s1;
		end else begin
			n_s2 <= n_x;
		end
		d_s2 <= d_s1;
		side_s2.empty <= empty_s1;
		side_s2.full <= ge_s1;
		side_s2.sm <= sm_s1;
	end

	assign out_valid = v_s2;
	assign num = n_s2;
	assign den = d_s2;
	assign side = side_s2;

endmodule

### rtl/fccm_divider.sv
module fccm_divider
	import fccm_pkg::*;
#(
	parameter int SAMPLE_BITS = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  logic [SAMPLE_BITS-1:0] num,
	input  logic [SAMPLE_BITS-1:0] den,
	input  side_t side_in,
	output logic out_valid,
	output logic [T_BITS-1:0] quot,
	output side_t side_out
);

	// restoring division of num * 2^T_BITS by den, num at most den
	logic v_s [DIV_STAGES];
	logic [SAMPLE_BITS-1:0] r_s [DIV_STAGES];
	logic [SAMPLE_BITS-1:0] d_s [DIV_STAGES];
	logic [T_BITS-1:0] q_s [DIV_STAGES];
	side_t side_s [DIV_STAGES];

	for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
		logic v_in;
		logic [SAMPLE_BITS-1:0] r_in, d_in, r_n;
		logic [T_BITS-1:0] q_in, q_n;
		logic [SAMPLE_BITS:0] r2;
		side_t s_in;

		if (k == 0) begin : g_first
			assign v_in = in_valid;
			assign r_in = num;
			assign d_in = den;
			assign q_in = '0;
			assign s_in = side_in;
		end else begin : g_next
			assign v_in = v_s[k-1];
			assign r_in = r_s[k-1];
			assign d_in = d_s[k-1];
			assign q_in = q_s[k-1];
			assign s_in = side_s[k-1];
		end

		always_comb begin
			r_n = r_in;
			q_n = q_in;
			r2 = '0;
			for (int j = 0; j < DIV_STEPS; j++) begin
				r2 = {r_n, 1'b0};
				if (r2 >= {1'b0, d_in}) begin
					r2 = r2 - {1'b0, d_in};
					q_n = {q_n[T_BITS-2:0], 1'b1};
				end else begin
					q_n = {q_n[T_BITS-2:0], 1'b0};
				end
				r_n = r2[SAMPLE_BITS-1:0];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else begin
				v_s[k] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			r_s[k] <= r_n;
			d_s[k] <= d_in;
			q_s[k] <= q_n;
			side_s[k] <= s_in;
		end
	end

	assign out_valid = v_s[DIV_STAGES-1];
	assign quot = q_s[DIV_STAGES-1];
	assign side_out = side_s[DIV_STAGES-1];

endmodule

### rtl/fccm_colour.sv
module fccm_colour
	import fccm_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  logic [T_BITS-1:0] quot,
	input  side_t side,
	input  mode_t mode,
	output logic out_valid,
	output logic [CHAN_BITS-1:0] red,
	output logic [CHAN_BITS-1:0] green,
	output logic [CHAN_BITS-1:0] blue
);

	// channel darkened by 255 * sm / 256, floored at zero
	function automatic logic [CHAN_BITS-1:0] darken(
		input logic [CHAN_BITS-1:0] c,
		input logic [16:0] smoke_term
	);
		logic signed [17:0] v;
		v = $signed({2'b00, c, 8'h00}) - $signed({1'b0, smoke_term});
		return (v <= 0) ? '0 : v[15:8];
	endfunction

	logic [T_BITS-1:0] t;
	logic [SEG_BITS-1:0] f;
	logic [SEG_BITS:0] g;
	logic [21:0] up_p, dn_p;
	logic [CHAN_BITS-1:0] up, down;
	logic [CHAN_BITS-1:0] r_x, g_x, b_x;

	logic v_s1;
	logic [CHAN_BITS-1:0] r_s1, g_s1, b_s1;
	logic [SMOKE_BITS-1:0] sm_s1;
	logic [16:0] sm_term;

	logic v_s2;
	logic [CHAN_BITS-1:0] r_s2, g_s2, b_s2;

	always_comb begin
		unique case (mode)
			MODE_RAMP, MODE_RAMP_SMOKE: begin
				priority if (side.empty) begin
					t = T_HALF;
				end else if (side.full) begin
					t = T_MAX;
				end else begin
					t = quot;
				end
			end
			MODE_GREY, MODE_SMOKE_RAMP: begin
				// smoke of one saturates just below one
				t = side.sm[8] ? T_MAX : {side.sm[7:0], 8'h00};
			end
			default: t = T_HALF;
		endcase
	end

	assign f = t[SEG_BITS-1:0];
	assign g = 15'd16384 - {1'b0, f};
	assign up_p = 22'(f) * 22'd255;
	assign dn_p = 22'(g) * 22'd255;
	assign up = up_p[21:14];
	assign down = dn_p[21:14];

	// blue, cyan, green, yellow, red
	always_comb begin
		unique case (t[T_BITS-1:SEG_BITS])
			2'd0: begin r_x = '0; g_x = up; b_x = 8'd255; end
			2'd1: begin r_x = '0; g_x = 8'd255; b_x = down; end
			2'd2: begin r_x = up; g_x = 8'd255; b_x = '0; end
			default: begin r_x = 8'd255; g_x = down; b_x = '0; end
		endcase
	end

	assign sm_term = 17'(sm_s1) * 17'd255;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		r_s1 <= r_x;
		g_s1 <= g_x;
		b_s1 <= b_x;
		sm_s1 <= side.sm;

		unique case (mode)
			MODE_RAMP, MODE_SMOKE_RAMP: begin
				r_s2 <= r_s1;
				g_s2 <= g_s1;
				b_s2 <= b_s1;
			end
			MODE_RAMP_SMOKE: begin
				r_s2 <= darken(r_s1, sm_term);
				g_s2 <= darken(g_s1, sm_term);
				b_s2 <= darken(b_s1, sm_term);
			end
			MODE_GREY: begin
				r_s2 <= sm_term[15:8];
				g_s2 <= sm_term[15:8];
				b_s2 <= sm_term[15:8];
			end
			default: begin
				r_s2 <= r_s1;
				g_s2 <= g_s1;
				b_s2 <= b_s1;
			end
		endcase
	end

	assign out_valid = v_s2;
	assign red = r_s2;
	assign green = g_s2;
	assign blue = b_s2;

endmodule

### rtl/false_colour_cell_mapper.sv
// throughput: one item per cycle, busy is never raised
// an item passes 2 front end stages, 8 divider stages at 2 quotient bits each, 2 colour stages
// results are shown for one cycle under done, the receiver cannot stall
// reset (arst_n low, asynchronous) empties the pipeline and sets mode 0,
// range_low 0 and range_high to the largest positive sample
module false_colour_cell_mapper
	import fccm_pkg::*;
#(
	parameter int SAMPLE_BITS = 16
) (
	input  logic clk,
	input  logic arst_n,
	// item handshake
	input  logic start,
	output logic busy,
	input  logic [SAMPLE_BITS-1:0] pressure,
	input  logic [SMOKE_BITS-1:0] smoke,
	// result strobe
	output logic done,
	output logic [CHAN_BITS-1:0] red,
	output logic [CHAN_BITS-1:0] green,
	output logic [CHAN_BITS-1:0] blue,
	// register write port
	input  logic cfg_we,
	input  logic [1:0] cfg_index,
	input  logic [SAMPLE_BITS-1:0] cfg_data
);

	// configuration registers, the user writes them only while no item is in flight, unenforced
	mode_t mode_q;
	logic [SAMPLE_BITS-1:0] range_low_q;
	logic [SAMPLE_BITS-1:0] range_high_q;

	logic accept;

	// front end to divider
	logic norm_valid;
	logic [SAMPLE_BITS-1:0] norm_num, norm_den;
	side_t norm_side;

	// divider to colour stages
	logic div_valid;
	logic [T_BITS-1:0] div_quot;
	side_t div_side;

	// pipeline never holds off an item
	assign busy = 1'b0;
	assign accept = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_RAMP;
			range_low_q <= '0;
			range_high_q <= {1'b0, {(SAMPLE_BITS-1){1'b1}}};
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_MODE: mode_q <= mode_t'(cfg_data[1:0]);
				CFG_RANGE_LOW: range_low_q <= cfg_data;
				CFG_RANGE_HIGH: range_high_q <= cfg_data;
				default: ; // unused index, write dropped
			endcase
		end
	end

	// clamp to the range and form numerator and denominator (2 stages)
	fccm_norm #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_norm (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(accept),
		.pressure(pressure),
		.smoke(smoke),
		.range_low(range_low_q),
		.range_high(range_high_q),
		.out_valid(norm_valid),
		.num(norm_num),
		.den(norm_den),
		.side(norm_side)
	);

	// pipelined restoring divider gives the Q0.16 fraction
	fccm_divider #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_divider (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(norm_valid),
		.num(norm_num),
		.den(norm_den),
		.side_in(norm_side),
		.out_valid(div_valid),
		.quot(div_quot),
		.side_out(div_side)
	);

	// ramp lookup, then smoke darkening or grey (2 stages)
	fccm_colour u_colour (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(div_valid),
		.quot(div_quot),
		.side(div_side),
		.mode(mode_q),
		.out_valid(done),
		.red(red),
		.green(green),
		.blue(blue)
	);

	// every result traces back to an item accepted a fixed time earlier
	assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(accept, LATENCY))
	else $error("result without matching item");

	assert property (@(posedge clk) disable iff (!arst_n)
		div_valid |-> $past(accept, 2 + DIV_STAGES))
	else $error("divider output out of step with accepted items");

	// grey mode gives equal channels
	assert property (@(posedge clk) disable iff (!arst_n)
		done && mode_q == MODE_GREY && $past(mode_q) == MODE_GREY |->
		red == green && green == blue)
	else $error("grey result with unequal channels");

endmodule

### tb/cell_colour_checker.sv
module cell_colour_checker
	import fccm_pkg::*;
#(
	parameter int SAMPLE_BITS = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic busy,
	input  logic [SAMPLE_BITS-1:0] pressure,
	input  logic [SMOKE_BITS-1:0] smoke,
	input  logic done,
	input  logic [CHAN_BITS-1:0] red,
	input  logic [CHAN_BITS-1:0] green,
	input  logic [CHAN_BITS-1:0] blue,
	input  logic cfg_we,
	input  logic [1:0] cfg_index,
	input  logic [SAMPLE_BITS-1:0] cfg_data,
	output int mismatches,
	output int outstanding
);

	typedef struct packed {
		logic [CHAN_BITS-1:0] r;
		logic [CHAN_BITS-1:0] g;
		logic [CHAN_BITS-1:0] b;
	} colour_t;

	// shadow copy of the register file
	mode_t colour_mode;
	logic [SAMPLE_BITS-1:0] range_low;
	logic [SAMPLE_BITS-1:0] range_high;

	colour_t pending_colours[$];
	int fail_count = 0;
	int pending_n = 0;

	assign mismatches = fail_count;
	assign outstanding = pending_n;

	// blue-cyan-green-yellow-red ramp of a Q0.16 fraction
	function automatic colour_t jet_ramp(input logic [T_BITS-1:0] t);
		int f;
		int up;
		int down;
		colour_t c;
		f = int'(t[SEG_BITS-1:0]);
		up = (255 * f) >> SEG_BITS;
		down = (255 * ((1 << SEG_BITS) - f)) >> SEG_BITS;
		case (t[T_BITS-1:SEG_BITS])
			2'd0: c = '{r: 8'd0, g: up[7:0], b: 8'd255};
			2'd1: c = '{r: 8'd0, g: 8'd255, b: down[7:0]};
			2'd2: c = '{r: up[7:0], g: 8'd255, b: 8'd0};
			default: c = '{r: 8'd255, g: down[7:0], b: 8'd0};
		endcase
		return c;
	endfunction

	function automatic colour_t cell_colour(input mode_t mode,
			input logic [SAMPLE_BITS-1:0] p_raw, input logic [SMOKE_BITS-1:0] smoke_raw);
		longint lo;
		longint hi;
		longint p;
		longint span;
		longint q;
		int sm;
		int v;
		int k;
		int chan [3];
		logic [T_BITS-1:0] t;
		colour_t c;
		lo = longint'($signed(range_low));
		hi = longint'($signed(range_high));
		p = longint'($signed(p_raw));
		sm = (smoke_raw > SMOKE_ONE) ? int'(SMOKE_ONE) : int'(smoke_raw);
		if (mode == MODE_GREY) begin
			v = (255 * sm) >> 8;
			c = '{r: v[7:0], g: v[7:0], b: v[7:0]};
		end else if (mode == MODE_SMOKE_RAMP) begin
			q = longint'(sm) * 256;
			if (q > longint'(T_MAX))
				q = longint'(T_MAX);
			c = jet_ramp(q[T_BITS-1:0]);
		end else begin
			// empty or inverted range sits at one half
			span = hi - lo;
			t = T_HALF;
			if (span > 0) begin
				if (p < lo)
					p = lo;
				if (p > hi)
					p = hi;
				q = ((p - lo) << T_BITS) / span;
				if (q > longint'(T_MAX))
					q = longint'(T_MAX);
				t = q[T_BITS-1:0];
			end
			c = jet_ramp(t);
			if (mode == MODE_RAMP_SMOKE) begin
				chan[0] = int'(c.r);
				chan[1] = int'(c.g);
				chan[2] = int'(c.b);
				for (k = 0; k < 3; k++) begin
					v = chan[k] * 256 - 255 * sm;
					chan[k] = (v <= 0) ? 0 : (v >> 8);
				end
				c = '{r: chan[0][7:0], g: chan[1][7:0], b: chan[2][7:0]};
			end
		end
		return c;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		colour_t want;
		if (!arst_n) begin
			colour_mode = MODE_RAMP;
			range_low = '0;
			range_high = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
			pending_colours.delete();
			pending_n = 0;
		end else begin
			if (done) begin
				if (pending_colours.size() == 0) begin
					fail_count++;
					$display("%0t: unexpected colour %0d/%0d/%0d, none expected",
						$time, red, green, blue);
				end else begin
					want = pending_colours.pop_front();
					if (red !== want.r) begin
						fail_count++;
						$display("%0t: red mismatch, expected %0d, got %0d", $time, want.r, red);
					end
					if (green !== want.g) begin
						fail_count++;
						$display("%0t: green mismatch, expected %0d, got %0d",
							$time, want.g, green);
					end
					if (blue !== want.b) begin
						fail_count++;
						$display("%0t: blue mismatch, expected %0d, got %0d", $time, want.b, blue);
					end
				end
			end
			if (start && !busy)
				pending_colours.push_back(cell_colour(colour_mode, pressure, smoke));
			if (cfg_we) begin
				case (cfg_index)
					CFG_MODE:       colour_mode = mode_t'(cfg_data[1:0]);
					CFG_RANGE_LOW:  range_low = cfg_data;
					CFG_RANGE_HIGH: range_high = cfg_data;
					default: ;
				endcase
			end
			pending_n = pending_colours.size();
		end
	end

endmodule

### tb/false_colour_cell_mapper_test.sv
module false_colour_cell_mapper_test;
	import fccm_pkg::*;

	localparam int SAMPLE_BITS = 16;
	localparam int PHASES = 16;
	localparam int PHASE_ITEMS = 125;
	// register index with nothing behind it
	localparam logic [1:0] CFG_UNUSED = 2'd3;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	logic [SAMPLE_BITS-1:0] pressure;
	logic [SMOKE_BITS-1:0] smoke;
	logic done;
	logic [CHAN_BITS-1:0] red;
	logic [CHAN_BITS-1:0] green;
	logic [CHAN_BITS-1:0] blue;
	logic cfg_we;
	logic [1:0] cfg_index;
	logic [SAMPLE_BITS-1:0] cfg_data;

	int mismatches;
	int outstanding;

	// sender gap odds in percent per cycle, and bookkeeping for the summary
	int idle_pct = 0;
	int items_sent = 0;
	int reg_writes = 0;

	false_colour_cell_mapper #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.pressure(pressure),
		.smoke(smoke),
		.done(done),
		.red(red),
		.green(green),
		.blue(blue),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// watches both channels and the register port, predicts and compares
	cell_colour_checker #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) i_checker (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.pressure(pressure),
		.smoke(smoke),
		.done(done),
		.red(red),
		.green(green),
		.blue(blue),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.mismatches(mismatches),
		.outstanding(outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// hard stop well beyond the slowest legal run
	initial begin
		#1000000;
		$display("false_colour_cell_mapper_test: FAIL");
		$finish;
	end

	// one item: optional gap cycles first, then hold start until the block takes it
	task automatic send_cell(input int p, input int s);
		@(negedge clk);
		while ($urandom_range(0, 99) < idle_pct) begin
			start = 1'b0;
			@(negedge clk);
		end
		start = 1'b1;
		pressure = p[SAMPLE_BITS-1:0];
		smoke = s[SMOKE_BITS-1:0];
		// busy read right after the edge is the value the edge saw
		do @(posedge clk); while (busy);
		items_sent++;
	endtask

	// stop sending, wait for every expected colour, then let the pipe run dry
	task automatic settle();
		int waited;
		waited = 0;
		@(negedge clk);
		start = 1'b0;
		while (outstanding != 0 && waited < 4 * LATENCY + 100) begin
			@(negedge clk);
			waited++;
		end
		repeat (LATENCY) @(negedge clk);
	endtask

	// single cycle register write, only issued while idle
	task automatic write_reg(input logic [1:0] idx, input int data);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = data[SAMPLE_BITS-1:0];
		@(negedge clk);
		cfg_we = 1'b0;
		reg_writes++;
	endtask

	initial begin
		int k;
		int lo;
		int hi;
		int a;
		int b;
		int p;
		int s;
		int r;
		int idle_profile [4];
		mode_t mode_cycle [4];

		idle_profile = '{0, 83, 0, 22};
		mode_cycle = '{MODE_RAMP, MODE_RAMP_SMOKE, MODE_GREY, MODE_SMOKE_RAMP};

		start = 1'b0;
		pressure = '0;
		smoke = '0;
		cfg_we = 1'b0;
		cfg_index = CFG_MODE;
		cfg_data = '0;
		arst_n = 1'b0;
		repeat (11) @(negedge clk);
		arst_n = 1'b1;

		// directed: reset settings, pressure ramp over 0..32767, ramp corners
		send_cell(-32768, 0);
		send_cell(0, 511);
		send_cell(8192, 0);
		send_cell(16384, 0);
		send_cell(24576, 0);
		send_cell(32767, 256);

		// a write to the spare index must leave the mode alone
		settle();
		write_reg(CFG_UNUSED, 32'hFFFF);
		send_cell(32767, 0);

		// smoke darkening over the full sample range, mode bits with junk above
		settle();
		write_reg(CFG_MODE, (32'h3FFF << 2) | int'(MODE_RAMP_SMOKE));
		write_reg(CFG_RANGE_LOW, -32768);
		write_reg(CFG_RANGE_HIGH, 32767);
		send_cell(32767, 0);
		send_cell(32767, 256);
		send_cell(0, 128);
		send_cell(-32768, 511);
		send_cell(16384, 1);

		// empty range gives one half whatever the sample
		settle();
		write_reg(CFG_RANGE_LOW, 500);
		write_reg(CFG_RANGE_HIGH, 500);
		send_cell(500, 0);
		send_cell(-32768, 300);

		// inverted range is treated as empty
		settle();
		write_reg(CFG_MODE, int'(MODE_RAMP));
		write_reg(CFG_RANGE_LOW, 32767);
		write_reg(CFG_RANGE_HIGH, -32768);
		send_cell(0, 0);
		send_cell(32767, 0);

		// grey levels, pressure ignored, smoke above one saturates
		settle();
		write_reg(CFG_MODE, int'(MODE_GREY));
		send_cell(-32768, 0);
		send_cell(32767, 128);
		send_cell(1, 255);
		send_cell(-1, 256);
		send_cell(12345, 511);

		// smoke through the ramp, top of smoke lands just below one
		settle();
		write_reg(CFG_MODE, int'(MODE_SMOKE_RAMP));
		send_cell(0, 0);
		send_cell(0, 64);
		send_cell(0, 255);
		send_cell(0, 256);
		send_cell(0, 511);

		// random phases: each mode under each sender gap profile, ranges rotate
		for (k = 0; k < PHASES; k++) begin
			settle();
			a = int'($urandom_range(0, 65535)) - 32768;
			b = int'($urandom_range(0, 65535)) - 32768;
			case (k % 6)
				0: begin
					lo = -32768;
					hi = 32767;
				end
				1: begin
					lo = 0;
					hi = 32767;
				end
				2: begin
					// narrow span stresses the divider remainder
					lo = int'($urandom_range(0, 65535 - 64)) - 32768;
					hi = lo + int'($urandom_range(1, 64));
				end
				3: begin
					lo = (a < b) ? a : b;
					hi = (a < b) ? b : a;
				end
				4: begin
					lo = a;
					hi = a;
				end
				default: begin
					lo = (a < b) ? b : a;
					hi = (a < b) ? a : b;
				end
			endcase
			write_reg(CFG_MODE, (int'($urandom_range(0, 16383)) << 2) | int'(mode_cycle[k % 4]));
			write_reg(CFG_RANGE_LOW, lo);
			write_reg(CFG_RANGE_HIGH, hi);
			idle_pct = idle_profile[(k / 4) % 4];

			repeat (PHASE_ITEMS) begin
				// now and then hold off until the pipe has drained
				if ($urandom_range(0, 199) == 0)
					settle();
				r = int'($urandom_range(0, 99));
				if (r < 10)
					p = r[0] ? 32767 : -32768;
				else if (r < 25)
					p = ($urandom_range(0, 1) ? hi : lo) + int'($urandom_range(0, 2)) - 1;
				else if (r < 75 && hi > lo)
					p = lo + int'($urandom_range(0, hi - lo));
				else
					p = int'($urandom_range(0, 65535)) - 32768;
				r = int'($urandom_range(0, 99));
				if (r < 10) begin
					case ($urandom_range(0, 2))
						0: s = 0;
						1: s = 256;
						default: s = 511;
					endcase
				end else if (r < 25)
					s = int'($urandom_range(257, 511));
				else
					s = int'($urandom_range(0, 256));
				send_cell(p, s);
			end
		end

		// drain and give the verdict
		settle();
		if (outstanding != 0)
			$display("%0t: %0d colours never arrived", $time, outstanding);
		$display("summary: %0d cells sent, %0d register writes", items_sent, reg_writes);
		$display("summary: all colour modes; full, reset, narrow, empty, inverted ranges");
		if (mismatches == 0 && outstanding == 0)
			$display("false_colour_cell_mapper_test: PASS");
		else
			$display("false_colour_cell_mapper_test: FAIL");
		$finish;
	end

endmodule
